// ===== sv/tma_pkg.sv =====
// Shared constants and elaboration-time table functions for the triangle minimum angle unit.
package tma_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_FRAC_DEF  = 8;
  localparam int RAD_FRAC        = 60;
  localparam int CORDIC_STEPS    = 48;
  localparam int SQRT_STEPS      = 32;
  localparam int SQRT_REM_W      = 36;
  localparam int SQRT_ROOT_W     = 32;
  localparam int PRE_STAGES      = 6;
  localparam int CORNER_LAT      = PRE_STAGES + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  // shift-subtract long division, only used to build constants
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) from the truncated Taylor series, 60 fractional bits
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] k;
    logic        done;
    p    = udiv64(64'd1 << RAD_FRAC, n);
    sum  = p;
    k    = 64'd1;
    done = 1'b0;
    for (int it = 0; it < 64; it++) begin
      if (!done) begin
        p = udiv64(udiv64(p, n), n);
        if (p == 64'd0) begin
          done = 1'b1;
        end else begin
          term = udiv64(p, (k << 1) + 64'd1);
          if (k[0]) sum = sum - term;
          else      sum = sum + term;
          k = k + 64'd1;
        end
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] QUARTER_PI = (64'd4 * atan_inv(64'd5)) - atan_inv(64'd239);
  localparam logic [63:0] HALF_PI    = QUARTER_PI << 1;
  localparam logic [63:0] PI_Q       = QUARTER_PI << 2;

  function automatic logic [63:0] atan_step(input int i);
    logic [63:0] v;
    if (i == 0) v = QUARTER_PI;
    else        v = atan_inv(64'd1 << i);
    return v;
  endfunction

  // position of the highest set bit plus one, zero for zero
  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) res = 7'(i + 1);
    end
    return res;
  endfunction

endpackage

// ===== sv/tma_sqrt_cell.sv =====
// One registered digit step of the integer square root chain.
module tma_sqrt_cell #(
  parameter int BIT_POS = 62,
  parameter int SIDE_W  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [tma_pkg::SQRT_REM_W-1:0]         in_rem,
  input  logic [tma_pkg::SQRT_ROOT_W-1:0]        in_root,
  input  logic [63:0]                            in_rad,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  output logic [tma_pkg::SQRT_REM_W-1:0]         out_rem,
  output logic [tma_pkg::SQRT_ROOT_W-1:0]        out_root,
  output logic [63:0]                            out_rad,
  output logic [SIDE_W-1:0]                      out_side
);

  logic [tma_pkg::SQRT_REM_W-1:0]  rem2;
  logic [tma_pkg::SQRT_REM_W-1:0]  trial;
  logic [tma_pkg::SQRT_REM_W-1:0]  rem_nxt;
  logic [tma_pkg::SQRT_ROOT_W-1:0] root_nxt;
  logic                            valid_r;
  logic [tma_pkg::SQRT_REM_W-1:0]  rem_r;
  logic [tma_pkg::SQRT_ROOT_W-1:0] root_r;
  logic [63:0]                     rad_r;
  logic [SIDE_W-1:0]               side_r;

  always_comb begin
    rem2  = {in_rem[tma_pkg::SQRT_REM_W-3:0], in_rad[BIT_POS+1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    if (rem2 >= trial) begin
      rem_nxt  = rem2 - trial;
      root_nxt = {in_root[tma_pkg::SQRT_ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem2;
      root_nxt = {in_root[tma_pkg::SQRT_ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= in_rad;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

// ===== sv/tma_cordic_cell.sv =====
// One registered CORDIC vectoring step.
module tma_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [63:0]  in_x,
  input  logic signed [63:0]  in_y,
  input  logic signed [63:0]  in_z,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [63:0]  out_x,
  output logic signed [63:0]  out_y,
  output logic signed [63:0]  out_z,
  output logic [SIDE_W-1:0]   out_side
);

  localparam logic signed [63:0] ANG = tma_pkg::atan_step(STEP);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [63:0] x_nxt;
  logic signed [63:0] y_nxt;
  logic signed [63:0] z_nxt;
  logic               valid_r;
  logic signed [63:0] x_r;
  logic signed [63:0] y_r;
  logic signed [63:0] z_r;
  logic [SIDE_W-1:0]  side_r;

  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    if (!in_y[63]) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANG;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_side  = side_r;

endmodule

// ===== sv/tma_corner.sv =====
// Interior angle at one corner: scaling, products, square root chain and CORDIC chain.
module tma_corner #(
  parameter int COORD_WIDTH = tma_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [COORD_WIDTH:0] u [3],
  input  logic signed [COORD_WIDTH:0] w [3],
  output logic                     out_valid,
  output logic [63:0]              theta
);

  localparam int NS = tma_pkg::SQRT_STEPS;
  localparam int NC = tma_pkg::CORDIC_STEPS;
  localparam int SW = 32;

  // stage 1: scale each vector below 2^30
  logic signed [63:0] ue [3];
  logic signed [63:0] we [3];
  logic [63:0]        ua [3];
  logic [63:0]        wa [3];
  logic [63:0]        um, wm;
  logic [6:0]         ul, wl;
  logic [5:0]         ush, wsh;
  logic signed [30:0] un_nxt [3];
  logic signed [30:0] wn_nxt [3];
  logic signed [30:0] un_r [3];
  logic signed [30:0] wn_r [3];
  logic               v1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ue[k] = 64'(u[k]);
      we[k] = 64'(w[k]);
      ua[k] = ue[k][63] ? 64'(-ue[k]) : 64'(ue[k]);
      wa[k] = we[k][63] ? 64'(-we[k]) : 64'(we[k]);
    end
    um = ua[0];
    if (ua[1] > um) um = ua[1];
    if (ua[2] > um) um = ua[2];
    wm = wa[0];
    if (wa[1] > wm) wm = wa[1];
    if (wa[2] > wm) wm = wa[2];
    ul  = tma_pkg::bit_len64(um);
    wl  = tma_pkg::bit_len64(wm);
    ush = (ul > 7'd30) ? 6'(ul - 7'd30) : 6'd0;
    wsh = (wl > 7'd30) ? 6'(wl - 7'd30) : 6'd0;
    for (int k = 0; k < 3; k++) begin
      un_nxt[k] = 31'(ue[k] >>> ush);
      wn_nxt[k] = 31'(we[k] >>> wsh);
    end
  end

  // stage 2: products
  logic signed [61:0] pr_nxt [9];
  logic signed [61:0] pr_r [9];
  logic               v2_r;

  always_comb begin
    pr_nxt[0] = un_r[1] * wn_r[2];
    pr_nxt[1] = un_r[2] * wn_r[1];
    pr_nxt[2] = un_r[2] * wn_r[0];
    pr_nxt[3] = un_r[0] * wn_r[2];
    pr_nxt[4] = un_r[0] * wn_r[1];
    pr_nxt[5] = un_r[1] * wn_r[0];
    pr_nxt[6] = un_r[0] * wn_r[0];
    pr_nxt[7] = un_r[1] * wn_r[1];
    pr_nxt[8] = un_r[2] * wn_r[2];
  end

  // stage 3: dot and cross magnitudes
  logic signed [63:0] dot;
  logic signed [63:0] cr [3];
  logic [63:0]        dm_nxt;
  logic [63:0]        cm_nxt [3];
  logic [63:0]        dm_r;
  logic [63:0]        cm_r [3];
  logic               neg3_r;
  logic               v3_r;

  always_comb begin
    dot   = 64'(pr_r[6]) + 64'(pr_r[7]) + 64'(pr_r[8]);
    cr[0] = 64'(pr_r[0]) - 64'(pr_r[1]);
    cr[1] = 64'(pr_r[2]) - 64'(pr_r[3]);
    cr[2] = 64'(pr_r[4]) - 64'(pr_r[5]);
    dm_nxt = dot[63] ? 64'(-dot) : 64'(dot);
    for (int k = 0; k < 3; k++) begin
      cm_nxt[k] = cr[k][63] ? 64'(-cr[k]) : 64'(cr[k]);
    end
  end

  // stage 4: common scaling below 2^31
  logic [63:0] mx;
  logic [6:0]  tl;
  logic [5:0]  tsh;
  logic [30:0] cs_nxt [3];
  logic [30:0] cs_r [3];
  logic [30:0] ux4_r;
  logic        neg4_r;
  logic        v4_r;

  always_comb begin
    mx = dm_r;
    for (int k = 0; k < 3; k++) begin
      if (cm_r[k] > mx) mx = cm_r[k];
    end
    tl  = tma_pkg::bit_len64(mx);
    tsh = (tl > 7'd31) ? 6'(tl - 7'd31) : 6'd0;
    for (int k = 0; k < 3; k++) begin
      cs_nxt[k] = 31'(cm_r[k] >> tsh);
    end
  end

  // stages 5 and 6: squares and their sum
  logic [61:0] sq_r [3];
  logic [30:0] ux5_r;
  logic        neg5_r;
  logic        v5_r;
  logic [63:0] rad_r;
  logic [30:0] ux6_r;
  logic        neg6_r;
  logic        v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r   <= un_nxt;
      wn_r   <= wn_nxt;
      pr_r   <= pr_nxt;
      dm_r   <= dm_nxt;
      cm_r   <= cm_nxt;
      neg3_r <= dot[63];
      cs_r   <= cs_nxt;
      ux4_r  <= 31'(dm_r >> tsh);
      neg4_r <= neg3_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= 62'(cs_r[k]) * 62'(cs_r[k]);
      end
      ux5_r  <= ux4_r;
      neg5_r <= neg4_r;
      rad_r  <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      ux6_r  <= ux5_r;
      neg6_r <= neg5_r;
    end
  end

  // square root chain
  logic                            sv [NS+1];
  logic [tma_pkg::SQRT_REM_W-1:0]  srem [NS+1];
  logic [tma_pkg::SQRT_ROOT_W-1:0] sroot [NS+1];
  logic [63:0]                     srad [NS+1];
  logic [SW-1:0]                   sside [NS+1];

  assign sv[0]    = v6_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad_r;
  assign sside[0] = {neg6_r, ux6_r};

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    tma_sqrt_cell #(
      .BIT_POS (62 - 2 * g),
      .SIDE_W  (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sv[g]),
      .in_rem    (srem[g]),
      .in_root   (sroot[g]),
      .in_rad    (srad[g]),
      .in_side   (sside[g]),
      .out_valid (sv[g+1]),
      .out_rem   (srem[g+1]),
      .out_root  (sroot[g+1]),
      .out_rad   (srad[g+1]),
      .out_side  (sside[g+1])
    );
  end

  // lift x and y so that the larger reaches 2^58
  logic [31:0]        uy;
  logic [31:0]        uxw;
  logic [31:0]        mxy;
  logic [6:0]         ml;
  logic [6:0]         lsh;
  logic signed [63:0] x0_r;
  logic signed [63:0] y0_r;
  logic               neg0_r;
  logic               v0_r;

  always_comb begin
    uy  = sroot[NS];
    uxw = {1'b0, sside[NS][30:0]};
    mxy = (uxw > uy) ? uxw : uy;
    ml  = tma_pkg::bit_len64(64'(mxy));
    lsh = (ml == 7'd0) ? 7'd0 : 7'd59 - ml;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= 64'(uxw) << lsh;
      y0_r   <= 64'(uy) << lsh;
      neg0_r <= sside[NS][31];
    end
  end

  // CORDIC chain
  logic               cv [NC+1];
  logic signed [63:0] cx [NC+1];
  logic signed [63:0] cy [NC+1];
  logic signed [63:0] cz [NC+1];
  logic [0:0]         cneg [NC+1];

  assign cv[0]   = v0_r;
  assign cx[0]   = x0_r;
  assign cy[0]   = y0_r;
  assign cz[0]   = '0;
  assign cneg[0] = neg0_r;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    tma_cordic_cell #(
      .STEP   (g),
      .SIDE_W (1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[g]),
      .in_x      (cx[g]),
      .in_y      (cy[g]),
      .in_z      (cz[g]),
      .in_side   (cneg[g]),
      .out_valid (cv[g+1]),
      .out_x     (cx[g+1]),
      .out_y     (cy[g+1]),
      .out_z     (cz[g+1]),
      .out_side  (cneg[g+1])
    );
  end

  // clamp and fold the obtuse case
  logic signed [63:0] zc;
  logic [63:0]        th_nxt;
  logic [63:0]        th_r;
  logic               vf_r;

  always_comb begin
    zc = cz[NC];
    if (zc[63]) zc = '0;
    if (zc > $signed(tma_pkg::HALF_PI)) zc = $signed(tma_pkg::HALF_PI);
    th_nxt = cneg[NC][0] ? tma_pkg::PI_Q - 64'(zc) : 64'(zc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= cv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r <= th_nxt;
    end
  end

  assign out_valid = vf_r;
  assign theta     = th_r;

endmodule

// ===== sv/triangle_min_angle_unit.sv =====
// Top level: smallest interior angle of a 3D triangle, one triangle per item.
//
// Input channel in_*: nine signed vertex coordinates (A, B, C) per item,
// accepted when in_valid is high and in_stall is low.
// Output channel out_*: out_min_angle in degrees with ANGLE_FRAC_BITS fraction
// bits and out_degenerate, taken when out_valid is high and out_stall is low.
// A triangle with a zero-length edge gives degenerate = 1 and angle 0.
// From acceptance to out_valid an item passes the edge stage, 88 corner
// stages (six arithmetic stages, a 32-cell square root chain, a lift stage,
// a 48-cell CORDIC chain and a fold stage), minimum, degree multiply, output.
// Throughput is one item per cycle unless stalled; all three corners run side by side.
// The whole pipeline advances together: while out_valid is high and the
// receiver holds out_stall, every stage holds and in_stall is raised.
// Reset clears every valid bit; the pipeline then accepts at once.
module triangle_min_angle_unit #(
  parameter int COORD_WIDTH     = tma_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = tma_pkg::ANGLE_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_az,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by_coord,
  input  logic signed [COORD_WIDTH-1:0] in_bz,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  input  logic signed [COORD_WIDTH-1:0] in_cz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_min_angle,
  output logic                          out_degenerate
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int LAT = tma_pkg::CORNER_LAT;
  localparam int RSH = 56 - ANGLE_FRAC_BITS;
  localparam logic [64:0] RND = 65'd1 << (55 - ANGLE_FRAC_BITS);
  localparam logic [31:0] ANG_LIMIT = 32'((60 << ANGLE_FRAC_BITS) + 16);

  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // edge stage
  logic signed [DW-1:0] a [3];
  logic signed [DW-1:0] b [3];
  logic signed [DW-1:0] c [3];
  logic signed [DW-1:0] ab_nxt [3];
  logic signed [DW-1:0] ac_nxt [3];
  logic signed [DW-1:0] bc_nxt [3];
  logic signed [DW-1:0] ab_r [3];
  logic signed [DW-1:0] ac_r [3];
  logic signed [DW-1:0] bc_r [3];
  logic signed [DW-1:0] ba_r [3];
  logic signed [DW-1:0] ca_r [3];
  logic signed [DW-1:0] cb_r [3];
  logic                 deg_nxt;
  logic                 deg_r;
  logic                 ev_r;

  always_comb begin
    a[0] = DW'(in_ax);
    a[1] = DW'(in_ay);
    a[2] = DW'(in_az);
    b[0] = DW'(in_bx);
    b[1] = DW'(in_by_coord);
    b[2] = DW'(in_bz);
    c[0] = DW'(in_cx);
    c[1] = DW'(in_cy);
    c[2] = DW'(in_cz);
    for (int k = 0; k < 3; k++) begin
      ab_nxt[k] = b[k] - a[k];
      ac_nxt[k] = c[k] - a[k];
      bc_nxt[k] = c[k] - b[k];
    end
    deg_nxt = (ab_nxt[0] == '0 && ab_nxt[1] == '0 && ab_nxt[2] == '0) ||
              (ac_nxt[0] == '0 && ac_nxt[1] == '0 && ac_nxt[2] == '0) ||
              (bc_nxt[0] == '0 && bc_nxt[1] == '0 && bc_nxt[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else if (en) begin
      ev_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ab_r[k] <= ab_nxt[k];
        ac_r[k] <= ac_nxt[k];
        bc_r[k] <= bc_nxt[k];
        ba_r[k] <= -ab_nxt[k];
        ca_r[k] <= -ac_nxt[k];
        cb_r[k] <= -bc_nxt[k];
      end
      deg_r <= deg_nxt;
    end
  end

  // three corners
  logic        va, vb, vc;
  logic [63:0] tha, thb, thc;

  tma_corner #(.COORD_WIDTH(COORD_WIDTH)) u_corner_a (
    .clk (clk), .rst_n (rst_n), .en (en), .in_valid (ev_r),
    .u (ab_r), .w (ac_r), .out_valid (va), .theta (tha)
  );

  tma_corner #(.COORD_WIDTH(COORD_WIDTH)) u_corner_b (
    .clk (clk), .rst_n (rst_n), .en (en), .in_valid (ev_r),
    .u (ba_r), .w (bc_r), .out_valid (vb), .theta (thb)
  );

  tma_corner #(.COORD_WIDTH(COORD_WIDTH)) u_corner_c (
    .clk (clk), .rst_n (rst_n), .en (en), .in_valid (ev_r),
    .u (ca_r), .w (cb_r), .out_valid (vc), .theta (thc)
  );

  // degenerate flag runs beside the corners
  logic deg_pipe_r [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_pipe_r[0] <= deg_r;
      for (int i = 1; i < LAT; i++) begin
        deg_pipe_r[i] <= deg_pipe_r[i-1];
      end
    end
  end

  // minimum, degree scaling, rounding
  logic [63:0] thm;
  logic [63:0] th_r;
  logic        mv_r;
  logic        mdg_r;
  logic [63:0] prod_r;
  logic        pv_r;
  logic        pdg_r;
  logic [64:0] rsum;
  logic [64:0] rs;
  logic [15:0] ang_nxt;
  logic [15:0] ang_r;
  logic        dg_out_r;

  always_comb begin
    thm = tha;
    if (thb < thm) thm = thb;
    if (thc < thm) thm = thc;
    rsum = {1'b0, prod_r} + RND;
    rs   = rsum >> RSH;
    if (pdg_r)                ang_nxt = '0;
    else if (rs > 65'hFFFF)   ang_nxt = 16'hFFFF;
    else                      ang_nxt = rs[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      mv_r        <= va;
      pv_r        <= mv_r;
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r     <= thm;
      mdg_r    <= deg_pipe_r[LAT-1];
      prod_r   <= 64'(th_r[61:28]) * 64'(tma_pkg::DEG_PER_RAD_Q24);
      pdg_r    <= mdg_r;
      ang_r    <= ang_nxt;
      dg_out_r <= pdg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_min_angle  = ang_r;
  assign out_degenerate = dg_out_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_min_angle == 16'd0)
    else $error("degenerate item with non-zero angle");

  a_max_sixty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> {16'd0, out_min_angle} <= ANG_LIMIT)
    else $error("smallest angle above sixty degrees");

  a_corner_sync: assert property (@(posedge clk) disable iff (!rst_n)
    va == vb && vb == vc)
    else $error("corner pipelines out of step");

  a_hold_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(deg_pipe_r[LAT-1]) && $stable(th_r))
    else $error("pipeline moved while stalled");

endmodule
